### src/ptl_pkg.sv
`timescale 1ns / 1ps
package ptl_pkg;

   localparam int DEF_MAX_PEERS = 32;
   localparam int ADDR_W        = 48;
   localparam int STAMP_W       = 48;
   localparam int REQ_W         = 3;
   localparam int STATUS_W      = 3;
   localparam int SLOT_W        = 5;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD       = 3'd0,
      REQ_LOOKUP    = 3'd1,
      REQ_SET_BUSY  = 3'd2,
      REQ_CLR_BUSY  = 3'd3,
      REQ_FLUSH     = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK        = 3'd0,
      RSP_INSERTED  = 3'd1,
      RSP_EVICTED   = 3'd2,
      RSP_FULL_BUSY = 3'd3,
      RSP_NO_ATTRS  = 3'd4,
      RSP_NOT_FOUND = 3'd5
   } status_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_status_type;

endpackage

### src/ptl_ram.sv
`timescale 1ns / 1ps
module ptl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ptl_ctrl.sv
`timescale 1ns / 1ps
module ptl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output ptl_pkg::ctrl_cmd_type  cmd,
   input  ptl_pkg::dp_status_type status
);

   ptl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptl_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ptl_pkg::ST_SCAN;
            end
         end
         ptl_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ptl_pkg::ST_DRAIN;
            end
         end
         ptl_pkg::ST_DRAIN:  state_in = ptl_pkg::ST_COMMIT;
         ptl_pkg::ST_COMMIT: state_in = ptl_pkg::ST_IDLE;
         default:            state_in = ptl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ptl_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ptl_pkg::ST_SCAN:   cmd.scan   = 1'b1;
         ptl_pkg::ST_DRAIN:  cmd        = '0;
         ptl_pkg::ST_COMMIT: cmd.commit = 1'b1;
         default:            cmd        = '0;
      endcase
   end

endmodule

### src/ptl_dpath.sv
`timescale 1ns / 1ps
module ptl_dpath #(
   parameter int MAX_PEERS = ptl_pkg::DEF_MAX_PEERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptl_pkg::ctrl_cmd_type         cmd,
   output ptl_pkg::dp_status_type        status,
   input  logic [ptl_pkg::REQ_W-1:0]     req_type,
   input  logic [ptl_pkg::ADDR_W-1:0]    req_peer_addr,
   input  logic                          req_attrs_present,
   output logic                          rsp_valid,
   output logic [ptl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ptl_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [ptl_pkg::ADDR_W-1:0]    rsp_evicted_addr
);

   localparam int IDX_W = $clog2(MAX_PEERS);

   // latched request
   ptl_pkg::req_code_type       req_ff;
   logic [ptl_pkg::ADDR_W-1:0]  addr_ff;
   logic                        attrs_ff;

   logic [IDX_W-1:0]            scan_cnt_ff;
   logic                        cmp_valid_ff;
   logic [IDX_W-1:0]            cmp_idx_ff;

   logic [MAX_PEERS-1:0]        valid_ff, valid_in;
   logic [MAX_PEERS-1:0]        busy_ff, busy_in;
   logic [ptl_pkg::STAMP_W-1:0] seq_ff;

   logic                        hit_found_ff, free_found_ff, victim_found_ff;
   logic [IDX_W-1:0]            hit_idx_ff, free_idx_ff, victim_idx_ff;
   logic [ptl_pkg::STAMP_W-1:0] victim_stamp_ff;
   logic [ptl_pkg::ADDR_W-1:0]  victim_addr_ff;

   logic [ptl_pkg::ADDR_W-1:0]  rd_addr_data;
   logic [ptl_pkg::STAMP_W-1:0] rd_stamp_data;

   logic                        rsp_valid_ff;
   logic [ptl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ptl_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [ptl_pkg::ADDR_W-1:0]  rsp_evicted_ff;

   // commit decisions
   ptl_pkg::status_code_type    status_in;
   logic [IDX_W-1:0]            wr_idx;
   logic [ptl_pkg::ADDR_W-1:0]  evicted_in;
   logic                        addr_we, stamp_we;

   logic                        ent_valid, ent_busy;

   assign status.scan_last = (scan_cnt_ff == IDX_W'(MAX_PEERS - 1));
   assign ent_valid = valid_ff[cmp_idx_ff];
   assign ent_busy  = busy_ff[cmp_idx_ff];

   ptl_ram #(.WIDTH(ptl_pkg::ADDR_W), .DEPTH(MAX_PEERS)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_we),
      .wr_addr (wr_idx),
      .wr_data (addr_ff),
      .rd_en   (cmd.scan),
      .rd_addr (scan_cnt_ff),
      .rd_data (rd_addr_data)
   );

   ptl_ram #(.WIDTH(ptl_pkg::STAMP_W), .DEPTH(MAX_PEERS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (wr_idx),
      .wr_data (seq_ff),
      .rd_en   (cmd.scan),
      .rd_addr (scan_cnt_ff),
      .rd_data (rd_stamp_data)
   );

   always_comb begin
      status_in  = ptl_pkg::RSP_NOT_FOUND;
      wr_idx     = hit_idx_ff;
      evicted_in = '0;
      addr_we    = 1'b0;
      stamp_we   = 1'b0;
      valid_in   = valid_ff;
      busy_in    = busy_ff;
      case (req_ff)
         ptl_pkg::REQ_ADD: begin
            if (!attrs_ff) begin
               status_in = ptl_pkg::RSP_NO_ATTRS;
            end else if (hit_found_ff) begin
               status_in = ptl_pkg::RSP_OK;
               stamp_we  = 1'b1;
            end else if (free_found_ff) begin
               status_in = ptl_pkg::RSP_INSERTED;
               wr_idx    = free_idx_ff;
               addr_we   = 1'b1;
               stamp_we  = 1'b1;
            end else if (victim_found_ff) begin
               status_in  = ptl_pkg::RSP_EVICTED;
               wr_idx     = victim_idx_ff;
               evicted_in = victim_addr_ff;
               addr_we    = 1'b1;
               stamp_we   = 1'b1;
            end else begin
               status_in = ptl_pkg::RSP_FULL_BUSY;
            end
            if (addr_we) begin
               valid_in[wr_idx] = 1'b1;
               busy_in[wr_idx]  = 1'b0;
            end
         end
         ptl_pkg::REQ_LOOKUP: begin
            if (hit_found_ff) begin
               status_in = ptl_pkg::RSP_OK;
            end
         end
         ptl_pkg::REQ_SET_BUSY: begin
            if (hit_found_ff) begin
               status_in           = ptl_pkg::RSP_OK;
               busy_in[hit_idx_ff] = 1'b1;
            end
         end
         ptl_pkg::REQ_CLR_BUSY: begin
            if (hit_found_ff) begin
               status_in           = ptl_pkg::RSP_OK;
               busy_in[hit_idx_ff] = 1'b0;
            end
         end
         ptl_pkg::REQ_FLUSH: begin
            status_in = ptl_pkg::RSP_OK;
            valid_in  = '0;
            busy_in   = '0;
         end
         default: status_in = ptl_pkg::RSP_NOT_FOUND;
      endcase
      addr_we  = addr_we && cmd.commit;
      stamp_we = stamp_we && cmd.commit;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         busy_ff      <= '0;
         seq_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan;
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            valid_ff <= valid_in;
            busy_ff  <= busy_in;
            if (stamp_we) begin
               seq_ff <= seq_ff + 1'b1;
            end
         end
      end
   end

   // request latch, scan and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff          <= ptl_pkg::req_code_type'(req_type);
         addr_ff         <= req_peer_addr;
         attrs_ff        <= req_attrs_present;
         scan_cnt_ff     <= '0;
         hit_found_ff    <= 1'b0;
         free_found_ff   <= 1'b0;
         victim_found_ff <= 1'b0;
      end else begin
         if (cmd.scan) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (cmp_valid_ff) begin
            if (ent_valid && !hit_found_ff && rd_addr_data == addr_ff) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= cmp_idx_ff;
            end
            if (!ent_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= cmp_idx_ff;
            end
            // strict compare keeps the lowest slot on equal stamps
            if (ent_valid && !ent_busy &&
                (!victim_found_ff || rd_stamp_data < victim_stamp_ff)) begin
               victim_found_ff <= 1'b1;
               victim_idx_ff   <= cmp_idx_ff;
               victim_stamp_ff <= rd_stamp_data;
               victim_addr_ff  <= rd_addr_data;
            end
         end
      end
      cmp_idx_ff <= scan_cnt_ff;
      if (cmd.commit) begin
         rsp_status_ff  <= status_in;
         rsp_evicted_ff <= evicted_in;
         if (status_in == ptl_pkg::RSP_OK && req_ff != ptl_pkg::REQ_FLUSH ||
             status_in == ptl_pkg::RSP_INSERTED || status_in == ptl_pkg::RSP_EVICTED) begin
            rsp_slot_ff <= ptl_pkg::SLOT_W'(wr_idx);
         end else begin
            rsp_slot_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_evicted_addr = rsp_evicted_ff;

endmodule

### src/peer_table_lru_evict_top.sv
`timescale 1ns / 1ps
// Peer address table with least-recently-seen replacement and pinned entries.
// Issue an item by raising start while busy is low; every item yields exactly
// one result, shown on the rsp_ ports for a single cycle with rsp_valid high.
// The receiver cannot stall, so it must take each result in that cycle. For
// each item the address and stamp memories are read one entry per cycle to
// find a match, the first free slot and the oldest unpinned entry, followed by
// a drain state for the registered read and a commit state. busy drops in
// the cycle the result appears, so a new item can be issued right then; the
// block takes no new item before the last one's result appears.
module peer_table_lru_evict_top #(
   parameter int MAX_PEERS = ptl_pkg::DEF_MAX_PEERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ptl_pkg::REQ_W-1:0]     req_type,
   input  logic [ptl_pkg::ADDR_W-1:0]    req_peer_addr,
   input  logic                          req_attrs_present,
   output logic                          rsp_valid,
   output logic [ptl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ptl_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [ptl_pkg::ADDR_W-1:0]    rsp_evicted_addr
);

   ptl_pkg::ctrl_cmd_type  cmd;
   ptl_pkg::dp_status_type dp_status;

   ptl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (dp_status)
   );

   ptl_dpath #(.MAX_PEERS(MAX_PEERS)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (dp_status),
      .req_type          (req_type),
      .req_peer_addr     (req_peer_addr),
      .req_attrs_present (req_attrs_present),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_addr  (rsp_evicted_addr)
   );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int PEERS = ptl_pkg::DEF_MAX_PEERS;
   localparam logic [ptl_pkg::REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [ptl_pkg::REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS = 1400;
   localparam int IDLE_PCT     = 28;
   localparam int MAX_GAP      = 50;
   localparam longint RUN_LIMIT_NS = 64'd20_000_000;

   class peer_lru_tracker;
      typedef struct {
         logic [ptl_pkg::STATUS_W-1:0] status;
         logic [ptl_pkg::SLOT_W-1:0]   slot;
         logic [ptl_pkg::ADDR_W-1:0]   evicted;
      } outcome_type;

      logic [ptl_pkg::ADDR_W-1:0]  addr_tab [PEERS];
      logic [ptl_pkg::STAMP_W-1:0] stamp_tab [PEERS];
      bit                          valid_tab [PEERS];
      bit                          pinned_tab [PEERS];
      logic [ptl_pkg::STAMP_W-1:0] seq_count;
      outcome_type                 awaited_outcomes [$];
      int                          errors;

      function new();
         int i;
         for (i = 0; i < PEERS; i++) begin
            addr_tab[i]   = '0;
            stamp_tab[i]  = '0;
            valid_tab[i]  = 1'b0;
            pinned_tab[i] = 1'b0;
         end
         seq_count = '0;
         errors    = 0;
      endfunction

      function void stamp_slot(int i);
         stamp_tab[i] = seq_count;
         seq_count    = seq_count + 1'b1;
      endfunction

      function int pending_count();
         return awaited_outcomes.size();
      endfunction

      // Apply one accepted item to the table copy and queue the outcome it must produce.
      function void log_request(logic [ptl_pkg::REQ_W-1:0] kind,
                                logic [ptl_pkg::ADDR_W-1:0] addr, logic attrs);
         outcome_type o;
         int          i;
         int          hit;
         int          free_slot;
         int          victim;
         int          target;
         o.status  = ptl_pkg::RSP_NOT_FOUND;
         o.slot    = '0;
         o.evicted = '0;
         hit       = -1;
         free_slot = -1;
         victim    = -1;
         target    = -1;
         for (i = 0; i < PEERS; i++) begin
            if (hit < 0 && valid_tab[i] && addr_tab[i] == addr)
               hit = i;
         end
         case (kind)
            ptl_pkg::REQ_ADD: begin
               if (!attrs) begin
                  o.status = ptl_pkg::RSP_NO_ATTRS;
               end else if (hit >= 0) begin
                  stamp_slot(hit);
                  o.status = ptl_pkg::RSP_OK;
                  o.slot   = ptl_pkg::SLOT_W'(hit);
               end else begin
                  for (i = 0; i < PEERS; i++) begin
                     if (!valid_tab[i]) begin
                        if (free_slot < 0)
                           free_slot = i;
                     end else if (!pinned_tab[i]) begin
                        if (victim < 0 || stamp_tab[i] < stamp_tab[victim])
                           victim = i;
                     end
                  end
                  if (free_slot >= 0) begin
                     o.status = ptl_pkg::RSP_INSERTED;
                     target   = free_slot;
                  end else if (victim >= 0) begin
                     o.status  = ptl_pkg::RSP_EVICTED;
                     o.evicted = addr_tab[victim];
                     target    = victim;
                  end else begin
                     o.status = ptl_pkg::RSP_FULL_BUSY;
                  end
                  if (target >= 0) begin
                     addr_tab[target]   = addr;
                     valid_tab[target]  = 1'b1;
                     pinned_tab[target] = 1'b0;
                     stamp_slot(target);
                     o.slot = ptl_pkg::SLOT_W'(target);
                  end
               end
            end
            ptl_pkg::REQ_LOOKUP, ptl_pkg::REQ_SET_BUSY, ptl_pkg::REQ_CLR_BUSY: begin
               if (hit >= 0) begin
                  if (kind == ptl_pkg::REQ_SET_BUSY)
                     pinned_tab[hit] = 1'b1;
                  else if (kind == ptl_pkg::REQ_CLR_BUSY)
                     pinned_tab[hit] = 1'b0;
                  o.status = ptl_pkg::RSP_OK;
                  o.slot   = ptl_pkg::SLOT_W'(hit);
               end
            end
            ptl_pkg::REQ_FLUSH: begin
               for (i = 0; i < PEERS; i++) begin
                  valid_tab[i]  = 1'b0;
                  pinned_tab[i] = 1'b0;
               end
               o.status = ptl_pkg::RSP_OK;
            end
            default: ;
         endcase
         awaited_outcomes.push_back(o);
      endfunction

      function void check_outcome(logic [ptl_pkg::STATUS_W-1:0] st,
                                  logic [ptl_pkg::SLOT_W-1:0] sl,
                                  logic [ptl_pkg::ADDR_W-1:0] ev);
         outcome_type want;
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result: status %0d slot %0d evicted %h",
                     $time, st, sl, ev);
            errors++;
            return;
         end
         want = awaited_outcomes.pop_front();
         if (st !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, st);
            errors++;
         end
         if (sl !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d actual %0d", $time, want.slot, sl);
            errors++;
         end
         if (ev !== want.evicted) begin
            $display("%0t: evicted_addr mismatch: expected %h actual %h",
                     $time, want.evicted, ev);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [ptl_pkg::REQ_W-1:0]    req_type = '0;
   logic [ptl_pkg::ADDR_W-1:0]   req_peer_addr = '0;
   logic                         req_attrs_present = 1'b0;
   logic                         rsp_valid;
   logic [ptl_pkg::STATUS_W-1:0] rsp_status;
   logic [ptl_pkg::SLOT_W-1:0]   rsp_slot;
   logic [ptl_pkg::ADDR_W-1:0]   rsp_evicted_addr;

   peer_lru_tracker tracker;
   bit              idle_enabled = 1'b1;
   int              items_sent = 0;
   logic [ptl_pkg::ADDR_W-1:0] addr_pool [$];

   peer_table_lru_evict_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_peer_addr    (req_peer_addr),
      .req_attrs_present(req_attrs_present),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_evicted_addr (rsp_evicted_addr)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         tracker.check_outcome(rsp_status, rsp_slot, rsp_evicted_addr);
   end

   function automatic logic [ptl_pkg::ADDR_W-1:0] rand_addr();
      return ptl_pkg::ADDR_W'({$urandom, $urandom});
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic issue_request(logic [ptl_pkg::REQ_W-1:0] kind,
                                logic [ptl_pkg::ADDR_W-1:0] addr, logic attrs);
      if (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
      end
      start             <= 1'b1;
      req_type          <= kind;
      req_peer_addr     <= addr;
      req_attrs_present <= attrs;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      tracker.log_request(kind, addr, attrs);
      items_sent++;
      @(negedge clock);
   endtask

   // Fill the table, pin every entry, hit the all-pinned refusal, unpin and evict one.
   task automatic fill_and_pin();
      logic [ptl_pkg::ADDR_W-1:0] members [PEERS];
      int                         i;
      int                         freed;
      issue_request(ptl_pkg::REQ_FLUSH, rand_addr(), 1'b0);
      for (i = 0; i < PEERS; i++) begin
         members[i] = rand_addr();
         members[i][ptl_pkg::SLOT_W-1:0] = ptl_pkg::SLOT_W'(i);
         issue_request(ptl_pkg::REQ_ADD, members[i], 1'b1);
      end
      for (i = 0; i < PEERS; i++)
         issue_request(ptl_pkg::REQ_SET_BUSY, members[i], 1'($urandom_range(1)));
      issue_request(ptl_pkg::REQ_ADD, rand_addr(), 1'b1);
      freed = $urandom_range(PEERS - 1);
      issue_request(ptl_pkg::REQ_CLR_BUSY, members[freed], 1'($urandom_range(1)));
      issue_request(ptl_pkg::REQ_ADD, rand_addr(), 1'b1);
      issue_request(ptl_pkg::REQ_LOOKUP, members[freed], 1'($urandom_range(1)));
   endtask

   task automatic new_pool();
      int n;
      int i;
      addr_pool.delete();
      n = $urandom_range(8, 48);
      for (i = 0; i < n; i++)
         addr_pool.push_back(rand_addr());
      if ($urandom_range(1)) begin
         addr_pool.push_back('0);
         addr_pool.push_back('1);
      end
   endtask

   task automatic random_request();
      int                         r;
      logic [ptl_pkg::ADDR_W-1:0] addr;
      r = $urandom_range(99);
      if ($urandom_range(9) == 0)
         addr = rand_addr();
      else
         addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
      if (r < 45)
         issue_request(ptl_pkg::REQ_ADD, addr, $urandom_range(9) != 0);
      else if (r < 60)
         issue_request(ptl_pkg::REQ_LOOKUP, addr, 1'($urandom_range(1)));
      else if (r < 72)
         issue_request(ptl_pkg::REQ_SET_BUSY, addr, 1'($urandom_range(1)));
      else if (r < 84)
         issue_request(ptl_pkg::REQ_CLR_BUSY, addr, 1'($urandom_range(1)));
      else if (r < 86)
         issue_request(ptl_pkg::REQ_FLUSH, addr, 1'($urandom_range(1)));
      else if (r < 89)
         issue_request(ptl_pkg::REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
                       addr, 1'($urandom_range(1)));
      else
         issue_request(ptl_pkg::REQ_ADD, rand_addr(), 1'b1);
   endtask

   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int directed_count;
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue_request(ptl_pkg::REQ_FLUSH, '0, 1'b0);
      issue_request(ptl_pkg::REQ_ADD, '0, 1'b0);
      issue_request(ptl_pkg::REQ_ADD, '0, 1'b1);
      issue_request(ptl_pkg::REQ_ADD, '1, 1'b1);
      issue_request(ptl_pkg::REQ_ADD, '0, 1'b1);
      issue_request(ptl_pkg::REQ_LOOKUP, '1, 1'b0);
      issue_request(ptl_pkg::REQ_LOOKUP, 48'h1234_5678_9abc, 1'b1);
      issue_request(ptl_pkg::REQ_SET_BUSY, '0, 1'b0);
      issue_request(ptl_pkg::REQ_CLR_BUSY, 48'h0000_0000_0001, 1'b0);
      issue_request(ptl_pkg::REQ_SET_BUSY, 48'h8000_0000_0000, 1'b1);
      issue_request(ptl_pkg::REQ_CLR_BUSY, '0, 1'b1);
      issue_request(REQ_SPARE_FIRST, '0, 1'b1);
      issue_request(REQ_SPARE_FIRST + 1'b1, '1, 1'b0);
      issue_request(REQ_SPARE_LAST, '1, 1'b1);
      issue_request(ptl_pkg::REQ_ADD, 48'haaaa_aaaa_aaaa, 1'b1);
      issue_request(ptl_pkg::REQ_ADD, 48'h5555_5555_5555, 1'b1);
      issue_request(ptl_pkg::REQ_LOOKUP, '0, 1'b1);
      issue_request(ptl_pkg::REQ_FLUSH, '1, 1'b1);
      issue_request(ptl_pkg::REQ_LOOKUP, '1, 1'b0);
      issue_request(ptl_pkg::REQ_ADD, '1, 1'b1);
      issue_request(ptl_pkg::REQ_ADD, '1, 1'b0);
      directed_count = items_sent;

      fill_and_pin();
      new_pool();
      while (items_sent < directed_count + RANDOM_ITEMS) begin
         // quiet stretch: issue back to back
         idle_enabled = !(items_sent >= directed_count + 500 &&
                          items_sent < directed_count + 900);
         if ((items_sent - directed_count) % 200 == 199)
            new_pool();
         if (items_sent - directed_count == 700)
            fill_and_pin();
         random_request();
      end
      start <= 1'b0;

      while (tracker.pending_count() != 0)
         @(posedge clock);
      repeat (PEERS + 8) @(posedge clock);
      if (tracker.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
